// ===== rtl/dpdf_pkg.sv =====
package dpdf_pkg;

    localparam int unsigned NUM_DIRS = 8;
    localparam int unsigned DIR_W    = 3;
    localparam int unsigned BTN_W    = 8;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned KIND_W   = 2;

    localparam logic [KIND_W-1:0] KIND_OTHER   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_PASS          = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STRAIGHT      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DIAGONAL      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BLANK_MIXED   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FOUR_STRAIGHT = 3'd5;
    localparam logic [MODE_W-1:0] MODE_FOUR_DIAGONAL = 3'd6;
    localparam logic [MODE_W-1:0] MODE_MAX           = MODE_FOUR_DIAGONAL;

    localparam logic [NUM_DIRS-1:0] EVEN_MASK = 8'h55;
    localparam logic [NUM_DIRS-1:0] ODD_MASK  = 8'hAA;

    typedef struct packed {
        logic [NUM_DIRS-1:0] raw;
        logic [NUM_DIRS-1:0] target;
        logic [NUM_DIRS-1:0] pressed;
    } pad_state_t;

    typedef struct packed {
        logic             ignored;
        logic             primary_valid;
        logic             primary_is_down;
        logic [BTN_W-1:0] primary_button;
        logic             extra_valid;
        logic [DIR_W-1:0] extra_button;
    } pad_result_t;

    typedef struct packed {
        logic             found;
        logic [DIR_W-1:0] index;
    } lowest_t;

    function automatic lowest_t lowest_bit(input logic [NUM_DIRS-1:0] v);
        lowest_t r;
        r.found = 1'b0;
        r.index = '0;
        for (int i = NUM_DIRS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r.found = 1'b1;
                r.index = DIR_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/dpdf_step.sv =====
module dpdf_step (
    input  logic [dpdf_pkg::MODE_W-1:0] pad_mode,
    input  logic [dpdf_pkg::KIND_W-1:0] event_kind,
    input  logic [dpdf_pkg::BTN_W-1:0]  button,
    input  dpdf_pkg::pad_state_t        state_in,
    output dpdf_pkg::pad_state_t        state_out,
    output dpdf_pkg::pad_result_t       result
);
    import dpdf_pkg::*;

    logic                is_button;
    logic                is_down;
    logic                pass;
    logic [NUM_DIRS-1:0] raw_next;
    logic [NUM_DIRS-1:0] even_bits;
    logic [NUM_DIRS-1:0] odd_bits;
    logic [NUM_DIRS-1:0] rot1;
    logic [NUM_DIRS-1:0] rot2;
    logic [NUM_DIRS-1:0] four;
    logic [NUM_DIRS-1:0] target_next;
    logic [NUM_DIRS-1:0] pressed_new;
    logic [NUM_DIRS-1:0] released_new;
    logic [NUM_DIRS-1:0] pressed_next;
    lowest_t             dn;
    lowest_t             up;

    assign is_button = (event_kind == KIND_PRESS) || (event_kind == KIND_RELEASE);
    assign is_down   = (event_kind == KIND_PRESS);
    assign pass      = (pad_mode < MODE_STRAIGHT) || (button >= BTN_W'(NUM_DIRS));

    always_comb begin
        raw_next = state_in.raw;
        raw_next[button[DIR_W-1:0]] = is_down;
    end

    assign even_bits = raw_next & EVEN_MASK;
    assign odd_bits  = raw_next & ODD_MASK;
    assign rot1      = {raw_next[0], raw_next[NUM_DIRS-1:1]};
    assign rot2      = {raw_next[1:0], raw_next[NUM_DIRS-1:2]};
    assign four      = raw_next | (rot1 & ~rot2);

    always_comb begin
        case (pad_mode)
            MODE_STRAIGHT: target_next = (|even_bits) ? even_bits : odd_bits;
            MODE_DIAGONAL: target_next = (|odd_bits) ? odd_bits : even_bits;
            MODE_BLANK_MIXED: begin
                if ((|even_bits) && !(|odd_bits)) begin
                    target_next = even_bits;
                end else if ((|odd_bits) && !(|even_bits)) begin
                    target_next = odd_bits;
                end else begin
                    target_next = '0;
                end
            end
            MODE_FOUR_STRAIGHT:
                target_next = (state_in.target & ODD_MASK) | (four & EVEN_MASK);
            MODE_FOUR_DIAGONAL:
                target_next = (state_in.target & EVEN_MASK) | (four & ODD_MASK);
            default: target_next = state_in.target;
        endcase
    end

    assign pressed_new  = target_next & ~state_in.pressed;
    assign released_new = ~target_next & state_in.pressed;
    assign dn = lowest_bit(pressed_new);
    assign up = lowest_bit(released_new);

    always_comb begin
        pressed_next = state_in.pressed;
        if (dn.found) begin
            pressed_next[dn.index] = 1'b1;
        end
        if (up.found) begin
            pressed_next[up.index] = 1'b0;
        end
    end

    always_comb begin
        state_out = state_in;
        result    = '0;
        if (!is_button) begin
            result.ignored = 1'b1;
        end else if (pass) begin
            result.primary_valid   = 1'b1;
            result.primary_is_down = is_down;
            result.primary_button  = button;
        end else begin
            state_out.raw     = raw_next;
            state_out.target  = target_next;
            state_out.pressed = pressed_next;
            if (dn.found) begin
                result.primary_valid   = 1'b1;
                result.primary_is_down = 1'b1;
                result.primary_button  = BTN_W'(dn.index);
            end
            if (up.found) begin
                result.extra_valid  = 1'b1;
                result.extra_button = up.index;
            end
        end
    end

endmodule

// ===== rtl/dpad_direction_filter.sv =====
// Channel  | Valid / ready        | Payload
// s_       | s_tvalid / s_tready  | s_tuser event_kind, s_tdata button
// m_       | m_tvalid / m_tready  | m_tuser flags, m_tdata buttons
// cfg_     | cfg_valid / cfg_ready| cfg_data pad_mode
//
// One request per cycle while m_tready is high; m_tvalid comes from the result register.
// The filter step and both lowest-bit encoders sit between the input and result registers.
// Pad state is updated when a request moves into the result register.
// A stalled result holds in place; one more request waits in the input register.
// Reset (aresetn low, synchronous) clears valid flags, pad state and pad_mode.
module dpad_direction_filter (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [dpdf_pkg::BTN_W-1:0]   s_tdata,   // [7:0] button
    input  logic [dpdf_pkg::KIND_W-1:0]  s_tuser,   // [1:0] event_kind
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,   // [7:0] primary_button, [10:8] extra_button
    output logic [3:0]                   m_tuser,   // [0] ignored, [1] primary_valid,
                                                    // [2] primary_is_down, [3] extra_valid
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [dpdf_pkg::MODE_W-1:0]  cfg_data
);
    import dpdf_pkg::*;

    logic              in_valid_reg;
    logic [BTN_W-1:0]  in_button_reg;
    logic [KIND_W-1:0] in_kind_reg;
    logic              out_valid_reg;
    pad_result_t       out_result_reg;
    pad_state_t        state_reg;
    pad_state_t        state_next;
    pad_result_t       result_next;
    logic [MODE_W-1:0] pad_mode_reg;
    logic              out_load;
    logic              in_load;

    assign out_load  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || out_load;
    assign in_load   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    dpdf_step u_step (
        .pad_mode   (pad_mode_reg),
        .event_kind (in_kind_reg),
        .button     (in_button_reg),
        .state_in   (state_reg),
        .state_out  (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_mode_reg <= MODE_PASS;
        end else if (cfg_valid && cfg_ready) begin
            pad_mode_reg <= (cfg_data > MODE_MAX) ? MODE_PASS : cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (in_load) begin
                in_valid_reg <= 1'b1;
            end else if (out_load) begin
                in_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_button_reg <= s_tdata;
            in_kind_reg   <= s_tuser;
        end
        if (out_load) begin
            out_result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_result_reg.extra_button, out_result_reg.primary_button};
    assign m_tuser  = {out_result_reg.extra_valid, out_result_reg.primary_is_down,
                       out_result_reg.primary_valid, out_result_reg.ignored};

`ifndef NO_ASSERTIONS
    a_ignored_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_result_reg.ignored)
            |-> (!out_result_reg.primary_valid && !out_result_reg.extra_valid))
        else $error("ignored result carries a button report");

    a_pass_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_result_reg.primary_valid
            && (out_result_reg.primary_button >= BTN_W'(NUM_DIRS)))
            |-> !out_result_reg.extra_valid)
        else $error("passthrough result carries a virtual release");

    a_pass_mode_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (pad_mode_reg < MODE_STRAIGHT) |=> $stable(state_reg))
        else $error("pad state changed in passthrough mode");
`endif

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    import dpdf_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int HOLD_OFF_CYCLES = 40;
    localparam int SETTLE_CYCLES   = 4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BTN_W-1:0]  button;
    } pad_event_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [BTN_W-1:0]    s_tdata   = '0;
    logic [KIND_W-1:0]   s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [15:0]         m_tdata;
    logic [3:0]          m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [MODE_W-1:0]   cfg_data  = '0;

    dpad_direction_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    pad_event_t          pending_events[$];
    pad_result_t         expected_results[$];
    int                  mismatches    = 0;
    int                  sent_count    = 0;
    int                  checked_count = 0;
    bit                  send_pause    = 1'b0;
    bit                  no_idle       = 1'b0;
    int                  hold_request  = 0;

    logic [MODE_W-1:0]   pad_mode_q  = MODE_PASS;
    logic [NUM_DIRS-1:0] raw_dirs    = '0;
    logic [NUM_DIRS-1:0] target_dirs = '0;
    logic [NUM_DIRS-1:0] held_dirs   = '0;
    logic [NUM_DIRS-1:0] gen_held    = '0;

    function automatic logic [NUM_DIRS-1:0] rotate_dirs(input logic [NUM_DIRS-1:0] v,
                                                        input int n);
        logic [2*NUM_DIRS-1:0] twice;
        twice = {v, v} >> n;
        return twice[NUM_DIRS-1:0];
    endfunction

    function automatic int first_set_dir(input logic [NUM_DIRS-1:0] v);
        for (int i = 0; i < NUM_DIRS; i++) begin
            if (v[i]) return i;
        end
        return -1;
    endfunction

    function automatic logic [NUM_DIRS-1:0] filter_dirs(input logic [NUM_DIRS-1:0] d,
                                                        input logic [NUM_DIRS-1:0] prev);
        logic [NUM_DIRS-1:0] e;
        logic [NUM_DIRS-1:0] o;
        logic [NUM_DIRS-1:0] four;
        e    = d & EVEN_MASK;
        o    = d & ODD_MASK;
        four = d | (rotate_dirs(d, 1) & ~rotate_dirs(d, 2));
        case (pad_mode_q)
            MODE_STRAIGHT:      return (e != 0) ? e : o;
            MODE_DIAGONAL:      return (o != 0) ? o : e;
            MODE_BLANK_MIXED: begin
                if (e != 0 && o == 0) return e;
                if (o != 0 && e == 0) return o;
                return '0;
            end
            MODE_FOUR_STRAIGHT: return (prev & ODD_MASK) | (four & EVEN_MASK);
            MODE_FOUR_DIAGONAL: return (prev & EVEN_MASK) | (four & ODD_MASK);
            default:            return prev;
        endcase
    endfunction

    function automatic pad_result_t predict_event(input logic [KIND_W-1:0] kind,
                                                  input logic [BTN_W-1:0] btn);
        pad_result_t         r;
        logic [NUM_DIRS-1:0] new_on;
        logic [NUM_DIRS-1:0] new_off;
        int                  dn;
        int                  up;
        r = '0;
        if (kind != KIND_PRESS && kind != KIND_RELEASE) begin
            r.ignored = 1'b1;
            return r;
        end
        if (pad_mode_q < MODE_STRAIGHT || btn >= NUM_DIRS) begin
            r.primary_valid   = 1'b1;
            r.primary_is_down = (kind == KIND_PRESS);
            r.primary_button  = btn;
            return r;
        end
        raw_dirs[btn[DIR_W-1:0]] = (kind == KIND_PRESS);
        target_dirs = filter_dirs(raw_dirs, target_dirs);
        new_on  = target_dirs & ~held_dirs;
        new_off = ~target_dirs & held_dirs;
        dn = first_set_dir(new_on);
        up = first_set_dir(new_off);
        if (dn >= 0) begin
            held_dirs[dn]     = 1'b1;
            r.primary_valid   = 1'b1;
            r.primary_is_down = 1'b1;
            r.primary_button  = BTN_W'(dn);
        end
        if (up >= 0) begin
            held_dirs[up]  = 1'b0;
            r.extra_valid  = 1'b1;
            r.extra_button = DIR_W'(up);
        end
        return r;
    endfunction

    function automatic pad_event_t random_event();
        pad_event_t       ev;
        int               sel;
        logic [DIR_W-1:0] d;
        sel = $urandom_range(0, 99);
        d   = DIR_W'($urandom_range(0, NUM_DIRS - 1));
        if (sel < 70) begin
            ev.button   = BTN_W'(d);
            ev.kind     = gen_held[d] ? KIND_RELEASE : KIND_PRESS;
            gen_held[d] = ~gen_held[d];
        end else if (sel < 80) begin
            ev.button = BTN_W'(d);
            ev.kind   = $urandom_range(0, 1) ? KIND_PRESS : KIND_RELEASE;
        end else if (sel < 90) begin
            ev.button = BTN_W'($urandom_range(0, 255));
            ev.kind   = $urandom_range(0, 1) ? KIND_PRESS : KIND_RELEASE;
        end else begin
            ev.button = BTN_W'($urandom);
            ev.kind   = $urandom_range(0, 1) ? KIND_OTHER : KIND_UNUSED;
        end
        return ev;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, want %0d", what, got, want);
        mismatches++;
    endtask

    task automatic push_event(input logic [KIND_W-1:0] kind, input logic [BTN_W-1:0] btn);
        pad_event_t ev;
        ev.kind   = kind;
        ev.button = btn;
        pending_events.push_back(ev);
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_events.size() != 0 || s_tvalid || expected_results.size() != 0
               || checked_count != sent_count);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        pad_mode_q = (v > MODE_MAX) ? MODE_PASS : v;
    endtask

    always @(posedge aclk) begin : drive_events
        logic       next_valid;
        int         gap_left;
        pad_event_t ev;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left  = 0;
        end else begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_event(s_tuser, s_tdata));
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!send_pause && pending_events.size() != 0) begin
                    if (!no_idle && $urandom_range(0, 5) == 0) begin
                        gap_left = $urandom_range(1, 5) - 1;
                    end else begin
                        ev         = pending_events.pop_front();
                        sent_count++;
                        s_tdata   <= ev.button;
                        s_tuser   <= ev.kind;
                        next_valid = 1'b1;
                    end
                end
            end
            s_tvalid <= next_valid;
        end
    end

    always @(posedge aclk) begin : watch_results
        pad_result_t want;
        logic        ready_next;
        int          hold_left;
        int          stall_left;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left  = 0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unrequested result", m_tuser, 0);
                end else begin
                    want = expected_results.pop_front();
                    checked_count++;
                    if (m_tuser[0] !== want.ignored)
                        report_mismatch("ignored", m_tuser[0], want.ignored);
                    if (m_tuser[1] !== want.primary_valid)
                        report_mismatch("primary_valid", m_tuser[1], want.primary_valid);
                    if (m_tuser[2] !== want.primary_is_down)
                        report_mismatch("primary_is_down", m_tuser[2], want.primary_is_down);
                    if (m_tdata[7:0] !== want.primary_button)
                        report_mismatch("primary_button", m_tdata[7:0], want.primary_button);
                    if (m_tuser[3] !== want.extra_valid)
                        report_mismatch("extra_valid", m_tuser[3], want.extra_valid);
                    if (m_tdata[10:8] !== want.extra_button)
                        report_mismatch("extra_button", m_tdata[10:8], want.extra_button);
                    if (m_tdata[15:11] !== 5'd0)
                        report_mismatch("tdata fill", m_tdata[15:11], 0);
                end
            end
            if (hold_request > 0 && hold_left == 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 5) - 1;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            m_tready <= ready_next;
        end
    end

    initial begin
        #400000;
        $display("dpad_direction_filter verification failed");
        $finish;
    end

    initial begin : run_test
        logic [MODE_W-1:0] mode;
        int                count;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // pass-through after reset, other events, unused kind
        push_event(KIND_OTHER, 8'hFF);
        push_event(KIND_UNUSED, 8'h00);
        push_event(KIND_PRESS, 8'd0);
        push_event(KIND_RELEASE, 8'hFF);

        write_mode(MODE_STRAIGHT);
        push_event(KIND_PRESS, 8'd0);
        push_event(KIND_PRESS, 8'd1);
        push_event(KIND_RELEASE, 8'd0);
        push_event(KIND_RELEASE, 8'd1);
        push_event(KIND_PRESS, 8'd8);

        write_mode(MODE_DIAGONAL);
        push_event(KIND_PRESS, 8'd0);
        push_event(KIND_PRESS, 8'd1);
        push_event(KIND_RELEASE, 8'd1);
        push_event(KIND_RELEASE, 8'd0);

        write_mode(MODE_BLANK_MIXED);
        push_event(KIND_PRESS, 8'd2);
        push_event(KIND_PRESS, 8'd3);
        push_event(KIND_RELEASE, 8'd2);
        push_event(KIND_RELEASE, 8'd3);

        write_mode(MODE_FOUR_STRAIGHT);
        push_event(KIND_PRESS, 8'd1);
        push_event(KIND_PRESS, 8'd7);
        push_event(KIND_RELEASE, 8'd1);

        write_mode(MODE_FOUR_DIAGONAL);
        push_event(KIND_PRESS, 8'd0);
        push_event(KIND_PRESS, 8'd2);
        push_event(KIND_RELEASE, 8'd0);

        // out-of-range mode falls back to pass-through
        write_mode(3'd7);
        push_event(KIND_PRESS, 8'd3);

        for (int phase = 0; phase < 18; phase++) begin
            if (phase < 8)
                mode = MODE_W'(phase);
            else if ($urandom_range(0, 3) != 0)
                mode = MODE_W'($urandom_range(MODE_STRAIGHT, MODE_MAX));
            else
                mode = MODE_W'($urandom_range(0, 7));
            if (phase == 17) begin
                wait_drained();
                no_idle = 1'b1;
            end
            write_mode(mode);
            count = $urandom_range(45, 65);
            for (int i = 0; i < count; i++)
                pending_events.push_back(random_event());
            if (phase == 3)
                hold_request = HOLD_OFF_CYCLES;
            if (phase == 5) begin
                do @(posedge aclk);
                while (pending_events.size() > count / 2);
                send_pause = 1'b1;
                do @(posedge aclk);
                while (s_tvalid || expected_results.size() != 0);
                send_pause = 1'b0;
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("dpad_direction_filter verification clean");
        end else begin
            $display("dpad_direction_filter verification failed");
        end
        $finish;
    end
endmodule
